// ----- sv/iccs_pkg.sv -----
// Shared types and constants for the icon color structure classifier.
package iccs_pkg;

	localparam int MAX_PIXELS_DEF = 65536;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHROMA_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_THR   = 2'd2;

	localparam logic [7:0] ALPHA_THR_RST  = 8'd24;
	localparam logic [7:0] CHROMA_THR_RST = 8'd30;
	localparam logic [7:0] LUMA_THR_RST   = 8'd48;

	localparam logic [7:0] LUMA_LOW_RST  = 8'd255;
	localparam logic [7:0] LUMA_HIGH_RST = 8'd0;

	// floor(x/3) == (x*683) >> 11 for x <= 765
	localparam logic [19:0] LUMA_RECIP = 20'd683;
	localparam int          LUMA_SHIFT = 11;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] chroma;
		logic [7:0] luma_spread;
	} thr_t;

	typedef struct packed {
		logic       covered;
		logic       chromatic;
		logic [7:0] luma;
		logic       last;
	} pix_attr_t;

endpackage

// ----- sv/iccs_pixel_stage.sv -----
// Input register and per-pixel coverage, chroma and luma evaluation.
module iccs_pixel_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          alpha,
	input  logic                last_pixel,
	input  iccs_pkg::thr_t      thr,
	input  logic                attr_take,
	output logic                attr_valid_s2,
	output iccs_pkg::pix_attr_t attr_s2
);

	logic       valid_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	logic [7:0] alpha_s1;
	logic       last_s1;

	logic       ready_s1;
	logic       ready_s2;
	logic [7:0] mx;
	logic [7:0] mn;
	logic [9:0] sum;
	logic [19:0] prod;
	iccs_pkg::pix_attr_t attr;

	assign ready_s2  = !attr_valid_s2 || attr_take;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && ready_s1) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			alpha_s1 <= alpha;
			last_s1  <= last_pixel;
		end
	end

	always_comb begin
		mx = red_s1;
		mn = red_s1;
		if (green_s1 > mx) mx = green_s1;
		if (blue_s1 > mx)  mx = blue_s1;
		if (green_s1 < mn) mn = green_s1;
		if (blue_s1 < mn)  mn = blue_s1;
		sum  = 10'(red_s1) + 10'(green_s1) + 10'(blue_s1);
		prod = 20'(sum) * iccs_pkg::LUMA_RECIP;
		attr.covered   = alpha_s1 >= thr.alpha;
		attr.chromatic = (mx - mn) > thr.chroma;
		attr.luma      = prod[iccs_pkg::LUMA_SHIFT +: 8];
		attr.last      = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			attr_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			attr_s2 <= attr;
		end
	end

endmodule

// ----- sv/iccs_accum.sv -----
// Per-image accumulators, end-of-image decision and result register.
module iccs_accum #(
	parameter int MAX_PIXELS = iccs_pkg::MAX_PIXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                attr_valid,
	input  iccs_pkg::pix_attr_t attr,
	input  logic [7:0]          luma_spread_thr,
	output logic                attr_take,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                keep_authored_color
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

	logic [CNT_W-1:0] covered_q;
	logic [CNT_W-1:0] chromatic_q;
	logic [7:0]       luma_low_q;
	logic [7:0]       luma_high_q;

	logic [CNT_W-1:0] covered_nxt;
	logic [CNT_W-1:0] chromatic_nxt;
	logic [7:0]       luma_low_nxt;
	logic [7:0]       luma_high_nxt;
	logic [7:0]       spread;
	logic             out_free;
	logic             flag;

	assign out_free  = !res_valid || !res_stall;
	assign attr_take = attr_valid && (!attr.last || out_free);

	always_comb begin
		covered_nxt   = covered_q;
		chromatic_nxt = chromatic_q;
		luma_low_nxt  = luma_low_q;
		luma_high_nxt = luma_high_q;
		if (attr.covered) begin
			if (covered_q < CNT_MAX) covered_nxt = covered_q + CNT_W'(1);
			if (attr.chromatic && chromatic_q < CNT_MAX) begin
				chromatic_nxt = chromatic_q + CNT_W'(1);
			end
			if (attr.luma < luma_low_q)  luma_low_nxt  = attr.luma;
			if (attr.luma > luma_high_q) luma_high_nxt = attr.luma;
		end
		spread = (luma_high_nxt >= luma_low_nxt) ? (luma_high_nxt - luma_low_nxt) : 8'd0;
		flag   = (covered_nxt != '0) &&
			(({chromatic_nxt, 2'b00} > {2'b00, covered_nxt}) || (spread > luma_spread_thr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			covered_q   <= '0;
			chromatic_q <= '0;
			luma_low_q  <= iccs_pkg::LUMA_LOW_RST;
			luma_high_q <= iccs_pkg::LUMA_HIGH_RST;
		end else if (attr_take) begin
			if (attr.last) begin
				covered_q   <= '0;
				chromatic_q <= '0;
				luma_low_q  <= iccs_pkg::LUMA_LOW_RST;
				luma_high_q <= iccs_pkg::LUMA_HIGH_RST;
			end else begin
				covered_q   <= covered_nxt;
				chromatic_q <= chromatic_nxt;
				luma_low_q  <= luma_low_nxt;
				luma_high_q <= luma_high_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= attr_take && attr.last;
		end
	end

	always_ff @(posedge clk) begin
		if (attr_take && attr.last) begin
			keep_authored_color <= flag;
		end
	end

endmodule

// ----- sv/icon_color_structure_classifier.sv -----
// Icon color structure classifier: top level with threshold registers.
// A last pixel's result passes the input, attribute and result registers.
// Throughput: one pixel per cycle; three register stages (input, pixel attributes,
// result), with stall propagating back only from an occupied, stalled result.
// Reset: arst_n clears pipeline valids and per-image state, thresholds load 24/30/48.
// Configuration writes take effect at once and are always ready.
module icon_color_structure_classifier #(
	parameter int MAX_PIXELS = iccs_pkg::MAX_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      alpha,
	input  logic                            last_pixel,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            keep_authored_color,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iccs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iccs_pkg::CFG_DATA_W-1:0] cfg_data
);

	iccs_pkg::thr_t      thr_q;
	iccs_pkg::pix_attr_t attr_s2;
	logic                attr_valid_s2;
	logic                attr_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.alpha       <= iccs_pkg::ALPHA_THR_RST;
			thr_q.chroma      <= iccs_pkg::CHROMA_THR_RST;
			thr_q.luma_spread <= iccs_pkg::LUMA_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iccs_pkg::REG_ALPHA_THR:  thr_q.alpha       <= cfg_data;
				iccs_pkg::REG_CHROMA_THR: thr_q.chroma      <= cfg_data;
				iccs_pkg::REG_LUMA_THR:   thr_q.luma_spread <= cfg_data;
				default: ;
			endcase
		end
	end

	iccs_pixel_stage u_pix (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.last_pixel    (last_pixel),
		.thr           (thr_q),
		.attr_take     (attr_take),
		.attr_valid_s2 (attr_valid_s2),
		.attr_s2       (attr_s2)
	);

	iccs_accum #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_acc (
		.clk                 (clk),
		.arst_n              (arst_n),
		.attr_valid          (attr_valid_s2),
		.attr                (attr_s2),
		.luma_spread_thr     (thr_q.luma_spread),
		.attr_take           (attr_take),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.keep_authored_color (keep_authored_color)
	);

endmodule

// ----- sv/iccs_checker.sv -----
// Port-level checker for the icon color structure classifier, with its bind.
module iccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic       last_pixel,
	input logic       res_valid,
	input logic       res_stall,
	input logic       keep_authored_color,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(keep_authored_color))
		else $error("result changed while stalled");

	// input backpressure only arises from a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input stalled with free result register");

	// a stalled pixel transfer holds its payload
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(red) && $stable(green) &&
			$stable(blue) && $stable(alpha) && $stable(last_pixel))
		else $error("pixel changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not accepted");

endmodule

bind icon_color_structure_classifier iccs_checker u_iccs_checker (.*);
